// File: sv/nand_boot_page_loader_macros.svh
// Assertion macros used by the checker file of the boot page loader
`ifndef NAND_BOOT_PAGE_LOADER_MACROS_SVH
`define NAND_BOOT_PAGE_LOADER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define NBPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define NBPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nbpl_pkg.sv
// Shared types, codes and constants of the boot page loader
`default_nettype none

package nbpl_pkg;

    localparam int ADDR_BITS = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] TIMING_RESET = 16'h0737;

    localparam logic [3:0] FT_SMALL  = 4'h6;
    localparam logic [3:0] FT_LARGE4 = 4'hc;
    localparam logic [3:0] FT_LARGE5 = 4'he;

    localparam logic CFG_TIMING = 1'b0;
    localparam logic CFG_TYPE   = 1'b1;

    localparam logic [7:0] CMD_RESET = 8'hff;
    localparam logic [7:0] CMD_READ0 = 8'h00;
    localparam logic [7:0] CMD_READ1 = 8'h30;

    localparam logic [10:0] SMALL_PAGE_BYTES = 11'd512;
    localparam logic [32:0] SMALL_PAGE_DEC   = 33'd512;
    localparam logic [32:0] LARGE_PAGE_DEC   = 33'd2048;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_READY = 2'd1,
        OP_DATA  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RESET_WAIT,
        PH_PAGE_WAIT,
        PH_READING
    } phase_t;

    typedef enum logic [3:0] {
        ACT_EN    = 4'd0,
        ACT_DIS   = 4'd1,
        ACT_SEL   = 4'd2,
        ACT_DESEL = 4'd3,
        ACT_CMD   = 4'd4,
        ACT_ADDR  = 4'd5,
        ACT_POLL  = 4'd6,
        ACT_READ  = 4'd7,
        ACT_WRITE = 4'd8
    } action_t;

    // What the back end has to play out for one accepted request
    typedef enum logic [2:0] {
        K_POLL,
        K_READ,
        K_WRITE,
        K_START_OK,
        K_START_FAIL,
        K_RESET_DONE,
        K_WRITE_NEXT,
        K_WRITE_END
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic [31:0] mem_addr;
        logic [31:0] offs;
        logic        large_pg;
        logic        five;
    } desc_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] value;
        logic [31:0] mem_addr;
        logic        failed;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

// File: sv/nbpl_front.sv
// Front end: config registers, copy state and request classification
`default_nettype none

module nbpl_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_write,
    input  wire logic            cfg_index,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            in_acc,
    input  wire logic [1:0]      operation,
    input  wire logic [31:0]     dest_address,
    input  wire logic [30:0]     byte_count,
    input  wire logic [20:0]     start_page,
    input  wire logic            ready_flag,
    input  wire logic [7:0]      data_byte,
    output logic                 desc_valid,
    output nbpl_pkg::desc_t      desc
);
    import nbpl_pkg::*;

    logic [15:0]          timing_reg;
    logic [3:0]           ftype_reg;
    phase_t               phase_reg, phase_next;
    logic [31:0]          page_reg, page_next;
    logic [ADDR_BITS-1:0] wptr_reg, wptr_next;
    logic [32:0]          rem_reg, rem_next;
    logic [10:0]          bip_reg, bip_next;
    logic                 large_reg, large_next;
    logic                 five_reg, five_next;

    op_t         op;
    logic        type_ok, type_large, type_five;
    logic [10:0] bip_inc;
    logic        page_end;
    logic [32:0] rem_sub;
    logic        more;
    logic [31:0] page_inc, offs_cur, offs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg <= TIMING_RESET;
            ftype_reg  <= FT_SMALL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TIMING: timing_reg <= cfg_data;
                CFG_TYPE:   ftype_reg  <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        op = op_t'(operation);
        case (ftype_reg)
            FT_SMALL:
            begin
                type_ok = 1'b1; type_large = 1'b0; type_five = 1'b0;
            end
            FT_LARGE4:
            begin
                type_ok = 1'b1; type_large = 1'b1; type_five = 1'b0;
            end
            FT_LARGE5:
            begin
                type_ok = 1'b1; type_large = 1'b1; type_five = 1'b1;
            end
            default:
            begin
                type_ok = 1'b0; type_large = 1'b0; type_five = 1'b0;
            end
        endcase
        bip_inc = bip_reg + 11'd1;
        // a large page wraps the 11-bit byte counter back to zero
        page_end  = large_reg ? (bip_inc == 11'd0) : (bip_inc == SMALL_PAGE_BYTES);
        rem_sub   = rem_reg - (large_reg ? LARGE_PAGE_DEC : SMALL_PAGE_DEC);
        more      = !rem_sub[32];
        page_inc  = page_reg + 32'd1;
        offs_cur  = large_reg ? (page_reg << 11) : (page_reg << 9);
        offs_next = large_reg ? (page_inc << 11) : (page_inc << 9);
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_acc)
        begin
            case (op)
                OP_START: phase_next = type_ok ? PH_RESET_WAIT : PH_IDLE;
                OP_READY:
                begin
                    if (ready_flag)
                    begin
                        case (phase_reg)
                            PH_RESET_WAIT: phase_next = PH_PAGE_WAIT;
                            PH_PAGE_WAIT:  phase_next = PH_READING;
                            default:       ;
                        endcase
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_READING && page_end)
                        phase_next = more ? PH_PAGE_WAIT : PH_IDLE;
                end
                default: ;
            endcase
        end
    end

    // next copy state
    always_comb
    begin
        page_next  = page_reg;
        wptr_next  = wptr_reg;
        rem_next   = rem_reg;
        bip_next   = bip_reg;
        large_next = large_reg;
        five_next  = five_reg;
        if (in_acc)
        begin
            case (op)
                OP_START:
                begin
                    if (type_ok)
                    begin
                        large_next = type_large;
                        five_next  = type_five;
                        wptr_next  = dest_address[ADDR_BITS-1:0];
                        rem_next   = {2'b00, byte_count};
                        page_next  = {11'd0, start_page};
                        bip_next   = 11'd0;
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_READING)
                    begin
                        wptr_next = wptr_reg + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                        bip_next  = bip_inc;
                        if (page_end)
                        begin
                            bip_next  = 11'd0;
                            page_next = page_inc;
                            rem_next  = rem_sub;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // request to the back end
    always_comb
    begin
        desc_valid    = 1'b0;
        desc.kind     = K_POLL;
        desc.value    = 16'd0;
        desc.mem_addr = 32'(wptr_reg);
        desc.offs     = offs_cur;
        desc.large_pg = large_reg;
        desc.five     = five_reg;
        if (in_acc)
        begin
            case (op)
                OP_START:
                begin
                    desc_valid = 1'b1;
                    desc.kind  = type_ok ? K_START_OK : K_START_FAIL;
                    desc.value = timing_reg;
                end
                OP_READY:
                begin
                    if (phase_reg == PH_RESET_WAIT || phase_reg == PH_PAGE_WAIT)
                    begin
                        desc_valid = 1'b1;
                        if (!ready_flag)
                            desc.kind = K_POLL;
                        else if (phase_reg == PH_RESET_WAIT)
                            desc.kind = K_RESET_DONE;
                        else
                            desc.kind = K_READ;
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_READING)
                    begin
                        desc_valid = 1'b1;
                        desc.value = {8'h00, data_byte};
                        desc.offs  = offs_next;
                        if (!page_end)
                            desc.kind = K_WRITE;
                        else if (more)
                            desc.kind = K_WRITE_NEXT;
                        else
                            desc.kind = K_WRITE_END;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            page_reg  <= 32'd0;
            wptr_reg  <= '0;
            rem_reg   <= 33'd0;
            bip_reg   <= 11'd0;
            large_reg <= 1'b0;
            five_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            page_reg  <= page_next;
            wptr_reg  <= wptr_next;
            rem_reg   <= rem_next;
            bip_reg   <= bip_next;
            large_reg <= large_next;
            five_reg  <= five_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/nbpl_queue.sv
// Short request queue between the front and back ends
`default_nettype none

module nbpl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  nbpl_pkg::desc_t      push_desc,
    input  wire logic            pop,
    output nbpl_pkg::desc_t      head,
    output logic                 nonempty,
    output logic                 full
);
    import nbpl_pkg::*;

    desc_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head     = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/nbpl_back.sv
// Back end: expands each request into flash and memory actions, one per cycle while the result queue has room
`default_nettype none

module nbpl_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  nbpl_pkg::desc_t      head,
    input  wire logic            q_nonempty,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic [3:0]           action,
    output logic [15:0]          value,
    output logic [31:0]          mem_address,
    output logic                 failed,
    output logic                 last
);
    import nbpl_pkg::*;

    desc_t              cur_reg;
    logic               cur_valid_reg;
    logic [3:0]         step_reg;

    res_t               res;
    action_t            op_action;
    logic [7:0]         op_value;
    logic               op_last;
    logic [3:0]         op_step;
    logic               emit, load;

    res_t               res_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] owptr_reg, orptr_reg;
    logic [Q_CNT_W-1:0] ocount_reg;
    logic               ofull, out_pop;

    // page opening sequence, indexed from the select
    always_comb
    begin
        op_step   = step_reg - ((cur_reg.kind == K_WRITE_NEXT) ? 4'd2 : 4'd1);
        op_action = ACT_ADDR;
        op_value  = 8'h00;
        op_last   = 1'b0;
        case (op_step)
            4'd0: op_action = ACT_SEL;
            4'd1:
            begin
                op_action = ACT_CMD;
                op_value  = CMD_READ0;
            end
            4'd2: op_action = ACT_ADDR;
            4'd3: op_value = cur_reg.large_pg ? 8'h00 : cur_reg.offs[16:9];
            4'd4: op_value = cur_reg.large_pg ? cur_reg.offs[18:11] : cur_reg.offs[24:17];
            4'd5: op_value = cur_reg.large_pg ? cur_reg.offs[26:19]
                                              : {1'b0, cur_reg.offs[31:25]};
            4'd6:
            begin
                if (!cur_reg.large_pg)
                begin
                    op_action = ACT_POLL;
                    op_last   = 1'b1;
                end
                else if (cur_reg.five)
                    op_value = {3'b000, cur_reg.offs[31:27]};
                else
                begin
                    op_action = ACT_CMD;
                    op_value  = CMD_READ1;
                end
            end
            4'd7:
            begin
                if (cur_reg.five)
                begin
                    op_action = ACT_CMD;
                    op_value  = CMD_READ1;
                end
                else
                begin
                    op_action = ACT_POLL;
                    op_last   = 1'b1;
                end
            end
            default:
            begin
                op_action = ACT_POLL;
                op_last   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res.action   = ACT_POLL;
        res.value    = 16'd0;
        res.mem_addr = 32'd0;
        res.failed   = 1'b0;
        res.last     = 1'b0;
        case (cur_reg.kind)
            K_POLL:
            begin
                res.action = ACT_POLL;
                res.last   = 1'b1;
            end
            K_READ:
            begin
                res.action = ACT_READ;
                res.last   = 1'b1;
            end
            K_START_FAIL:
            begin
                if (step_reg == 4'd0)
                begin
                    res.action = ACT_EN;
                    res.value  = cur_reg.value;
                end
                else
                begin
                    res.action = ACT_DIS;
                    res.failed = 1'b1;
                    res.last   = 1'b1;
                end
            end
            K_START_OK:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        res.action = ACT_EN;
                        res.value  = cur_reg.value;
                    end
                    4'd1: res.action = ACT_SEL;
                    4'd2:
                    begin
                        res.action = ACT_CMD;
                        res.value  = {8'h00, CMD_RESET};
                    end
                    default:
                    begin
                        res.action = ACT_POLL;
                        res.last   = 1'b1;
                    end
                endcase
            end
            K_RESET_DONE:
            begin
                if (step_reg == 4'd0)
                    res.action = ACT_DESEL;
                else
                begin
                    res.action = op_action;
                    res.value  = {8'h00, op_value};
                    res.last   = op_last;
                end
            end
            default:
            begin
                // data byte, possibly closing a page
                if (step_reg == 4'd0)
                begin
                    res.action   = ACT_WRITE;
                    res.value    = cur_reg.value;
                    res.mem_addr = cur_reg.mem_addr;
                    res.last     = (cur_reg.kind == K_WRITE);
                end
                else if (step_reg == 4'd1)
                    res.action = ACT_DESEL;
                else if (cur_reg.kind == K_WRITE_END)
                begin
                    res.action = ACT_DIS;
                    res.last   = 1'b1;
                end
                else
                begin
                    res.action = op_action;
                    res.value  = {8'h00, op_value};
                    res.last   = op_last;
                end
            end
        endcase
    end

    assign emit  = cur_valid_reg && !ofull;
    assign load  = !cur_valid_reg || (emit && res.last);
    assign q_pop = load && q_nonempty;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
        end
        else if (load)
        begin
            cur_valid_reg <= q_nonempty;
            step_reg      <= 4'd0;
        end
        else if (emit)
            step_reg <= step_reg + 4'd1;
    end

    // result queue toward the consumer
    assign ofull       = (ocount_reg == Q_CNT_W'(Q_DEPTH));
    assign empty       = (ocount_reg == '0);
    assign out_pop     = pop && !empty;
    assign action      = res_reg[orptr_reg].action;
    assign value       = res_reg[orptr_reg].value;
    assign mem_address = res_reg[orptr_reg].mem_addr;
    assign failed      = res_reg[orptr_reg].failed;
    assign last        = res_reg[orptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg[owptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owptr_reg  <= '0;
            orptr_reg  <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            if (emit)
                owptr_reg <= owptr_reg + 1'b1;
            if (out_pop)
                orptr_reg <= orptr_reg + 1'b1;
            case ({emit, out_pop})
                2'b10:   ocount_reg <= ocount_reg + 1'b1;
                2'b01:   ocount_reg <= ocount_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/nand_boot_page_loader.sv
// Top level of the NAND boot page copy sequencer
// Usage:
//   Requests enter through push/full: start a copy (destination, byte count,
//   first page), a sampled flash ready bit, or a byte from the flash data port.
//   Results leave through empty/pop, oldest first: controller enable/disable,
//   chip select/deselect, command, address, poll, read and memory write
//   actions. The last result caused by a request carries last = 1; requests
//   that cause nothing produce no result.
//   cfg_write with cfg_index 0 sets the timing word, index 1 the flash type
//   nibble. Write them only while no copy is in flight.
// Result flow:
//   A request passes through the request queue, the back end's current
//   request register and the result queue before its first result shows.
//   While the result queue has room, the back end plays out one result per
//   cycle, so data bytes sustain one per cycle; a request has at most 11 results.
// Reset and stalls:
//   Reset empties both queues, returns to idle and restores the register
//   defaults (timing 0x0737, flash type 0x6). While pop is low, results
//   hold; full rises once the 4-entry request queue fills.
`default_nettype none

module nand_boot_page_loader (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] dest_address,
    input  wire logic [30:0] byte_count,
    input  wire logic [20:0] start_page,
    input  wire logic        ready_flag,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       action,
    output logic [15:0]      value,
    output logic [31:0]      mem_address,
    output logic             failed,
    output logic             last
);
    import nbpl_pkg::*;

    logic  in_acc;
    logic  desc_valid;
    desc_t desc;
    desc_t head;
    logic  q_nonempty, q_pop;

    assign in_acc = push && !full;

    nbpl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_acc       (in_acc),
        .operation    (operation),
        .dest_address (dest_address),
        .byte_count   (byte_count),
        .start_page   (start_page),
        .ready_flag   (ready_flag),
        .data_byte    (data_byte),
        .desc_valid   (desc_valid),
        .desc         (desc)
    );

    nbpl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_valid),
        .push_desc (desc),
        .pop       (q_pop),
        .head      (head),
        .nonempty  (q_nonempty),
        .full      (full)
    );

    nbpl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_nonempty  (q_nonempty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .action      (action),
        .value       (value),
        .mem_address (mem_address),
        .failed      (failed),
        .last        (last)
    );

endmodule

`default_nettype wire

// File: sv/nbpl_checker.sv
// Port-level checks of the boot page loader, bound to the top level
`default_nettype none

`include "nand_boot_page_loader_macros.svh"

module nbpl_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  action,
    input wire logic [15:0] value,
    input wire logic [31:0] mem_address,
    input wire logic        failed,
    input wire logic        last
);
    import nbpl_pkg::*;

    logic        shown;
    logic        stall;
    logic        is_write;
    logic [53:0] res_bits;

    assign shown    = !empty;
    assign stall    = !empty && !pop;
    assign is_write = (action == ACT_WRITE);
    assign res_bits = {action, value, mem_address, failed, last};

    `NBPL_ASSERT_NEXT(a_result_holds, stall, shown && $stable(res_bits), "result moved")
    `NBPL_ASSERT_NOW(a_fail_on_dis, shown && failed, action == ACT_DIS && last, "stray failed")
    `NBPL_ASSERT_NOW(a_addr_on_write, shown && !is_write, mem_address == '0, "stray address")
    `NBPL_ASSERT_NOW(a_value_width, shown && action != ACT_EN, value[15:8] == '0, "wide value")

endmodule

bind nand_boot_page_loader nbpl_port_checks u_checker (.*);

`default_nettype wire
